### sv/warm_cold_led_dimmer_controller_unit_assert.svh
// assertion macros for the warm/cold dimmer checker
`ifndef WARM_COLD_LED_DIMMER_CONTROLLER_UNIT_ASSERT_SVH
`define WARM_COLD_LED_DIMMER_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication, quiet during reset
`define WCLD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dimmer check failed");

// next-cycle implication, quiet during reset
`define WCLD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dimmer check failed");

`endif

### sv/wcld_pkg.sv
package wcld_pkg;

  // input opcodes
  typedef enum logic [2:0] {
    OP_TICK,
    OP_PRESS,
    OP_RELEASE,
    OP_CLICK,
    OP_HOLD,
    OP_TURN,
    OP_PTURN,
    OP_TRIPLE
  } op_t;

  // configuration register indexes
  localparam logic [1:0] CFG_FAST_STEP     = 2'd0;
  localparam logic [1:0] CFG_FADE_INTERVAL = 2'd1;
  localparam logic [1:0] CFG_HUE_TIMEOUT   = 2'd2;
  localparam logic [1:0] CFG_OFF_FORGET    = 2'd3;

  // register reset values
  localparam logic [7:0]  FAST_STEP_RST     = 8'd10;
  localparam logic [7:0]  FADE_INTERVAL_RST = 8'd1;
  localparam logic [15:0] HUE_TIMEOUT_RST   = 16'd10000;
  localparam logic [21:0] OFF_FORGET_RST    = 22'd3600000;

  // fixed hue and level codes
  localparam logic [7:0] HUE_MID  = 8'd127;
  localparam logic [7:0] LVL_FULL = 8'd255;

  localparam logic [24:0] GAMMA_BIAS = 25'd130305;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_MIX,
    S_SQ_W,
    S_CU_W,
    S_SQ_C,
    S_CU_C,
    S_GAM_C,
    S_DONE
  } state_t;

  // cubic gamma: zero stays zero, else (v^3 + bias) >> 16
  function automatic logic [7:0] gamma_of(input logic [23:0] cube, input logic [7:0] v);
    logic [24:0] sum;
    sum = {1'b0, cube} + GAMMA_BIAS;
    return (v == 8'd0) ? 8'd0 : sum[23:16];
  endfunction

endpackage

### sv/warm_cold_led_dimmer_controller_unit.sv
// Warm/cold two-channel lamp controller.
// Input channel (in_valid/in_stall) carries one event word: opcode, direction
// and fast. Opcode 0 is a millisecond tick, the others are button/encoder
// events. Every input word gives exactly one result word on the output
// channel (out_valid/out_stall): gamma shaped warm/cold levels, a flag that
// says whether this word recomputed them, and the mode, hue, brightness and
// target after the event.
// An event that leaves the levels alone goes from S_EXEC to S_DONE; one that
// recomputes them runs S_MIX, S_SQ_W, S_CU_W, S_SQ_C, S_CU_C and S_GAM_C
// between: the single shared 16x8 multiplier forms v*v then v*v*v per channel.
// in_stall is high while an event is being worked on. A finished result sits
// in the output register, so the next event is taken while it waits; if the
// receiver still stalls when the following result is ready, the sequencer
// holds and in_stall stays high until the register frees up.
// Configuration (cfg_we, cfg_index, cfg_data) is to be written by the user only
// while idle; the block does not enforce this. Synchronous reset clears all lamp
// state, loads the register defaults and empties the output register.
module warm_cold_led_dimmer_controller_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic        direction,
  input  logic        fast,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  warm_level,
  output logic [7:0]  cold_level,
  output logic        levels_updated,
  output logic        in_hue_mode,
  output logic [7:0]  hue_now,
  output logic [7:0]  brightness_now,
  output logic [7:0]  target_now,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [21:0] cfg_data
);
  import wcld_pkg::*;

  state_t state, state_next;

  // configuration
  logic [7:0]  fast_step;
  logic [7:0]  fade_interval_ms;
  logic [15:0] hue_timeout_ms;
  logic [21:0] off_forget_ms;

  // lamp state
  logic        lamp_on, lamp_on_next;
  logic        hue_mode, hue_mode_next;
  logic [7:0]  hue, hue_next;
  logic [7:0]  brightness, brightness_next;
  logic [7:0]  target, target_next;
  logic [7:0]  hue_buffer, hue_buffer_next;
  logic [7:0]  bright_buffer, bright_buffer_next;
  logic [7:0]  saved_hue, saved_hue_next;
  logic [7:0]  saved_bright, saved_bright_next;
  logic        off_timer_running, off_timer_running_next;
  logic [22:0] off_elapsed, off_elapsed_next;
  logic [16:0] hue_idle_elapsed, hue_idle_elapsed_next;
  logic [8:0]  fade_elapsed, fade_elapsed_next;
  logic [7:0]  warm_drive, cold_drive;
  logic        updated, updated_next;

  // captured event word and datapath registers
  op_t         op_q;
  logic        dir_q, fast_q;
  logic [7:0]  w_q, c_q;
  logic [23:0] prod;

  // shared multiplier
  logic [15:0] mul_a;
  logic [7:0]  mul_b;
  logic [23:0] mul_p;

  // turn arithmetic
  logic [8:0]  turn_step;
  logic [9:0]  turn_up;

  // level mix
  logic [7:0]  mix_delta, mix_w, mix_c;

  logic        out_free;

  assign out_free = !out_valid || !out_stall;
  assign mul_p    = {8'd0, mul_a} * {16'd0, mul_b};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fast_step        <= FAST_STEP_RST;
      fade_interval_ms <= FADE_INTERVAL_RST;
      hue_timeout_ms   <= HUE_TIMEOUT_RST;
      off_forget_ms    <= OFF_FORGET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FAST_STEP:     fast_step        <= cfg_data[7:0];
        CFG_FADE_INTERVAL: fade_interval_ms <= cfg_data[7:0];
        CFG_HUE_TIMEOUT:   hue_timeout_ms   <= cfg_data[15:0];
        CFG_OFF_FORGET:    off_forget_ms    <= cfg_data;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_EXEC;
      S_EXEC:  state_next = updated_next ? S_MIX : S_DONE;
      S_MIX:   state_next = S_SQ_W;
      S_SQ_W:  state_next = S_CU_W;
      S_CU_W:  state_next = S_SQ_C;
      S_SQ_C:  state_next = S_CU_C;
      S_CU_C:  state_next = S_GAM_C;
      S_GAM_C: state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs: stall and multiplier operands
  always_comb begin
    in_stall = 1'b1;
    mul_a    = {8'd0, w_q};
    mul_b    = w_q;
    unique case (state)
      S_IDLE: in_stall = 1'b0;
      S_CU_W: mul_a = prod[15:0];
      S_SQ_C: begin
        mul_a = {8'd0, c_q};
        mul_b = c_q;
      end
      S_CU_C: begin
        mul_a = prod[15:0];
        mul_b = c_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // turn target step: one, plus the fast step when fast is set
  assign turn_step = 9'd1 + (fast_q ? {1'b0, fast_step} : 9'd0);
  assign turn_up   = {2'b00, target} + {1'b0, turn_step};

  // event execution on the captured word
  always_comb begin
    lamp_on_next           = lamp_on;
    hue_mode_next          = hue_mode;
    hue_next               = hue;
    brightness_next        = brightness;
    target_next            = target;
    hue_buffer_next        = hue_buffer;
    bright_buffer_next     = bright_buffer;
    saved_hue_next         = saved_hue;
    saved_bright_next      = saved_bright;
    off_timer_running_next = off_timer_running;
    off_elapsed_next       = off_elapsed;
    hue_idle_elapsed_next  = hue_idle_elapsed;
    fade_elapsed_next      = fade_elapsed;
    updated_next           = 1'b0;
    unique case (op_q) inside
      OP_TICK: begin
        // saturating timers
        if (!(&fade_elapsed)) fade_elapsed_next = fade_elapsed + 9'd1;
        if (!(&hue_idle_elapsed)) hue_idle_elapsed_next = hue_idle_elapsed + 17'd1;
        if (off_timer_running) begin
          if (!(&off_elapsed)) off_elapsed_next = off_elapsed + 23'd1;
          if (off_elapsed_next > {1'b0, off_forget_ms}) off_timer_running_next = 1'b0;
        end
        // hue mode timeout
        if (lamp_on && hue_mode && hue_idle_elapsed_next > {1'b0, hue_timeout_ms}) begin
          hue_mode_next         = 1'b0;
          target_next           = brightness;
          hue_idle_elapsed_next = '0;
        end
        // one fade step toward the target
        if (hue_mode_next && hue != target_next) begin
          if (fade_elapsed_next > {1'b0, fade_interval_ms}) begin
            hue_next              = (hue < target_next) ? hue + 8'd1 : hue - 8'd1;
            fade_elapsed_next     = '0;
            hue_idle_elapsed_next = '0;
            updated_next          = 1'b1;
          end
        end else if (!hue_mode_next && brightness != target_next) begin
          if (fade_elapsed_next > {1'b0, fade_interval_ms}) begin
            brightness_next   = (brightness < target_next) ? brightness + 8'd1
                                                           : brightness - 8'd1;
            fade_elapsed_next = '0;
            updated_next      = 1'b1;
          end
        end
      end
      OP_PRESS: begin
        hue_mode_next = 1'b0;
        if (!off_timer_running) begin
          hue_buffer_next    = saved_hue;
          bright_buffer_next = saved_bright;
        end
        hue_next     = hue_buffer_next;
        target_next  = bright_buffer_next;
        lamp_on_next = 1'b1;
      end
      OP_RELEASE: begin
        off_timer_running_next = 1'b1;
        off_elapsed_next       = '0;
        hue_buffer_next        = hue;
        if (hue_mode || brightness == target) bright_buffer_next = brightness;
        hue_mode_next = 1'b0;
        target_next   = '0;
        lamp_on_next  = 1'b0;
      end
      OP_CLICK: begin
        if (lamp_on) begin
          hue_mode_next         = !hue_mode;
          target_next           = hue_mode ? brightness : hue;
          hue_idle_elapsed_next = '0;
        end
      end
      OP_HOLD, OP_PTURN: begin
        if (lamp_on) begin
          hue_mode_next = 1'b0;
          if (op_q == OP_HOLD) hue_next = HUE_MID;
          else                 hue_next = dir_q ? LVL_FULL : 8'd0;
          target_next = LVL_FULL;
          if (brightness == LVL_FULL) updated_next = 1'b1;
        end
      end
      OP_TURN: begin
        if (lamp_on) begin
          if (dir_q) target_next = turn_up[9:8] != 2'b00 ? LVL_FULL : turn_up[7:0];
          else if ({1'b0, target} < turn_step) target_next = '0;
          else target_next = target - turn_step[7:0];
        end
      end
      OP_TRIPLE: begin
        if (lamp_on) begin
          hue_mode_next     = 1'b0;
          target_next       = brightness;
          saved_hue_next    = hue;
          saved_bright_next = brightness;
        end
      end
      default: ;
    endcase
  end

  // lamp state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lamp_on           <= 1'b0;
      hue_mode          <= 1'b0;
      hue               <= '0;
      brightness        <= '0;
      target            <= '0;
      hue_buffer        <= '0;
      bright_buffer     <= '0;
      saved_hue         <= '0;
      saved_bright      <= '0;
      off_timer_running <= 1'b0;
      off_elapsed       <= '0;
      hue_idle_elapsed  <= '0;
      fade_elapsed      <= '0;
      updated           <= 1'b0;
    end else if (state == S_EXEC) begin
      lamp_on           <= lamp_on_next;
      hue_mode          <= hue_mode_next;
      hue               <= hue_next;
      brightness        <= brightness_next;
      target            <= target_next;
      hue_buffer        <= hue_buffer_next;
      bright_buffer     <= bright_buffer_next;
      saved_hue         <= saved_hue_next;
      saved_bright      <= saved_bright_next;
      off_timer_running <= off_timer_running_next;
      off_elapsed       <= off_elapsed_next;
      hue_idle_elapsed  <= hue_idle_elapsed_next;
      fade_elapsed      <= fade_elapsed_next;
      updated           <= updated_next;
    end
  end

  // capture the event word
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op_q   <= op_t'(opcode);
      dir_q  <= direction;
      fast_q <= fast;
    end
  end

  // hue/brightness mix into warm and cold levels
  always_comb begin
    if (!hue[7]) begin
      mix_delta = (hue == HUE_MID) ? 8'd0 : LVL_FULL - {hue[6:0], 1'b0};
      mix_w     = brightness;
      mix_c     = (brightness > mix_delta) ? brightness - mix_delta : 8'd0;
    end else begin
      mix_delta = (hue == LVL_FULL) ? LVL_FULL : {hue[6:0], 1'b0};
      mix_c     = brightness;
      mix_w     = (brightness > mix_delta) ? brightness - mix_delta : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MIX) begin
      w_q <= mix_w;
      c_q <= mix_c;
    end
  end

  // square then cube through the shared multiplier
  always_ff @(posedge clk) begin
    if (state == S_SQ_W || state == S_CU_W || state == S_SQ_C || state == S_CU_C)
      prod <= mul_p;
  end

  // gamma drive levels
  always_ff @(posedge clk) begin
    if (rst) begin
      warm_drive <= '0;
      cold_drive <= '0;
    end else begin
      if (state == S_SQ_C)  warm_drive <= gamma_of(prod, w_q);
      if (state == S_GAM_C) cold_drive <= gamma_of(prod, c_q);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      warm_level     <= warm_drive;
      cold_level     <= cold_drive;
      levels_updated <= updated;
      in_hue_mode    <= hue_mode;
      hue_now        <= hue;
      brightness_now <= brightness;
      target_now     <= target;
    end
  end

endmodule

### sv/wcld_checker.sv
`include "warm_cold_led_dimmer_controller_unit_assert.svh"

module wcld_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  warm_level,
  input logic [7:0]  cold_level,
  input logic        levels_updated,
  input logic [7:0]  hue_now,
  input logic [7:0]  brightness_now,
  input logic [7:0]  target_now
);
  import wcld_pkg::*;

  // an accepted word keeps in_stall high in S_EXEC and in the state that follows it
  `WCLD_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall ##1 in_stall)

  // a stalled result word holds
  `WCLD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(warm_level) && $stable(cold_level) && $stable(target_now))

  // dark lamp gives dark levels when they are recomputed
  `WCLD_ASSERT_NOW(a_dark_levels, out_valid && levels_updated && brightness_now == 8'd0, warm_level == 8'd0 && cold_level == 8'd0)

  // mid hue drives both channels equally
  `WCLD_ASSERT_NOW(a_mid_hue_balanced, out_valid && levels_updated && hue_now == HUE_MID, warm_level == cold_level)

endmodule

bind warm_cold_led_dimmer_controller_unit wcld_checker u_wcld_checker (.*);

### tb/tb.sv
import wcld_pkg::*;

// one output word of the dimmer
typedef struct packed {
  logic [7:0] warm;
  logic [7:0] cold;
  logic       upd;
  logic       hmode;
  logic [7:0] hue;
  logic [7:0] bright;
  logic [7:0] target;
} dimmer_word_t;

// tracks lamp state and checks output words in order
class lamp_state_tracker;
  logic [7:0]  fast_step;
  logic [7:0]  fade_interval;
  logic [15:0] hue_timeout;
  logic [21:0] off_forget;

  logic        lamp_on;
  logic        hue_mode;
  logic [7:0]  hue;
  logic [7:0]  bright;
  logic [7:0]  target;
  logic [7:0]  hue_buf;
  logic [7:0]  bright_buf;
  logic [7:0]  saved_hue;
  logic [7:0]  saved_bright;
  logic        off_running;
  logic [22:0] off_elapsed;
  logic [16:0] idle_elapsed;
  logic [8:0]  fade_elapsed;
  logic [7:0]  warm;
  logic [7:0]  cold;

  dimmer_word_t due_words[$];
  int fail_count;

  function new();
    fast_step     = FAST_STEP_RST;
    fade_interval = FADE_INTERVAL_RST;
    hue_timeout   = HUE_TIMEOUT_RST;
    off_forget    = OFF_FORGET_RST;
    lamp_on       = 1'b0;
    hue_mode      = 1'b0;
    hue           = '0;
    bright        = '0;
    target        = '0;
    hue_buf       = '0;
    bright_buf    = '0;
    saved_hue     = '0;
    saved_bright  = '0;
    off_running   = 1'b0;
    off_elapsed   = '0;
    idle_elapsed  = '0;
    fade_elapsed  = '0;
    warm          = '0;
    cold          = '0;
    fail_count    = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [21:0] val);
    case (idx)
      CFG_FAST_STEP:     fast_step = val[7:0];
      CFG_FADE_INTERVAL: fade_interval = val[7:0];
      CFG_HUE_TIMEOUT:   hue_timeout = val[15:0];
      CFG_OFF_FORGET:    off_forget = val;
      default: ;
    endcase
  endfunction

  // cubic curve, zero kept at zero
  function logic [7:0] shaped_level(logic [7:0] v);
    int unsigned cube;
    if (v == 8'd0) return 8'd0;
    cube = v;
    cube = cube * cube * cube + 32'd130305;
    return cube[23:16];
  endfunction

  // split brightness into warm and cold by hue
  function void remix();
    int h, b, d, w, c;
    h = hue;
    b = bright;
    if (h < 128) begin
      d = (h == 127) ? 0 : 255 - 2 * h;
      w = b;
      c = (b > d) ? b - d : 0;
    end else begin
      d = (h == 255) ? 255 : 2 * (h - 128);
      c = b;
      w = (b > d) ? b - d : 0;
    end
    warm = shaped_level(8'(w));
    cold = shaped_level(8'(c));
  endfunction

  function logic [7:0] toward_target(logic [7:0] v);
    return (v < target) ? v + 8'd1 : v - 8'd1;
  endfunction

  function dimmer_word_t apply_event(op_t op, logic dir, logic fst);
    dimmer_word_t res;
    logic upd;
    int t;
    upd = 1'b0;
    if (op == OP_TICK) begin
      if (fade_elapsed != '1) fade_elapsed = fade_elapsed + 1'b1;
      if (idle_elapsed != '1) idle_elapsed = idle_elapsed + 1'b1;
      if (off_running) begin
        if (off_elapsed != '1) off_elapsed = off_elapsed + 1'b1;
        if (off_elapsed > off_forget) off_running = 1'b0;
      end
      // hue mode times out back to brightness
      if (lamp_on && hue_mode && idle_elapsed > hue_timeout) begin
        hue_mode = 1'b0;
        target = bright;
        idle_elapsed = '0;
      end
      // one fade step on the active channel
      if (hue_mode && hue != target) begin
        if (fade_elapsed > fade_interval) begin
          hue = toward_target(hue);
          fade_elapsed = '0;
          idle_elapsed = '0;
          remix();
          upd = 1'b1;
        end
      end else if (!hue_mode && bright != target) begin
        if (fade_elapsed > fade_interval) begin
          bright = toward_target(bright);
          fade_elapsed = '0;
          remix();
          upd = 1'b1;
        end
      end
    end else if (op == OP_PRESS) begin
      hue_mode = 1'b0;
      if (!off_running) begin
        hue_buf = saved_hue;
        bright_buf = saved_bright;
      end
      hue = hue_buf;
      target = bright_buf;
      lamp_on = 1'b1;
    end else if (op == OP_RELEASE) begin
      off_running = 1'b1;
      off_elapsed = '0;
      hue_buf = hue;
      if (hue_mode || bright == target) bright_buf = bright;
      hue_mode = 1'b0;
      target = '0;
      lamp_on = 1'b0;
    end else if (lamp_on) begin
      case (op)
        OP_CLICK: begin
          hue_mode = !hue_mode;
          target = hue_mode ? hue : bright;
          idle_elapsed = '0;
        end
        OP_HOLD, OP_PTURN: begin
          hue_mode = 1'b0;
          if (op == OP_HOLD) hue = HUE_MID;
          else hue = dir ? 8'd255 : 8'd0;
          target = LVL_FULL;
          if (bright == LVL_FULL) begin
            remix();
            upd = 1'b1;
          end
        end
        OP_TURN: begin
          t = target;
          t = dir ? t + 1 + (fst ? int'(fast_step) : 0) : t - 1 - (fst ? int'(fast_step) : 0);
          if (t < 0) t = 0;
          if (t > 255) t = 255;
          target = 8'(t);
        end
        default: begin
          hue_mode = 1'b0;
          target = bright;
          saved_hue = hue;
          saved_bright = bright;
        end
      endcase
    end
    res.warm   = warm;
    res.cold   = cold;
    res.upd    = upd;
    res.hmode  = hue_mode;
    res.hue    = hue;
    res.bright = bright;
    res.target = target;
    return res;
  endfunction

  function void take_event(op_t op, logic dir, logic fst);
    due_words.push_back(apply_event(op, dir, fst));
  endfunction

  function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function void match_output(dimmer_word_t got);
    dimmer_word_t want;
    if (due_words.size() == 0) begin
      $error("output word with none due");
      fail_count++;
      return;
    end
    want = due_words.pop_front();
    cmp_field("warm_level", want.warm, got.warm);
    cmp_field("cold_level", want.cold, got.cold);
    cmp_field("levels_updated", 8'(want.upd), 8'(got.upd));
    cmp_field("in_hue_mode", 8'(want.hmode), 8'(got.hmode));
    cmp_field("hue_now", want.hue, got.hue);
    cmp_field("brightness_now", want.bright, got.bright);
    cmp_field("target_now", want.target, got.target);
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int PHASE_WORDS  = 160;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  opcode = '0;
  logic        direction = 1'b0;
  logic        fast = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  warm_level;
  logic [7:0]  cold_level;
  logic        levels_updated;
  logic        in_hue_mode;
  logic [7:0]  hue_now;
  logic [7:0]  brightness_now;
  logic [7:0]  target_now;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [21:0] cfg_data = '0;

  lamp_state_tracker tracker;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int words_sent = 0;
  int cycle_count = 0;

  warm_cold_led_dimmer_controller_unit dut (.*);

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // cycle limit
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[warm_cold_led_dimmer_controller_unit] ERROR");
    $finish;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // output word monitor
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && !out_stall)
        tracker.match_output({warm_level, cold_level, levels_updated, in_hue_mode,
                              hue_now, brightness_now, target_now});
    end
  end

  // one event word, with random sender gaps ahead of it
  task automatic send_word(op_t op, logic dir, logic fst);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    direction <= dir;
    fast      <= fst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_event(op, dir, fst);
    words_sent++;
  endtask

  task automatic send_rand_bits(op_t op);
    send_word(op, 1'($urandom), 1'($urandom));
  endtask

  task automatic tick_run(int n);
    repeat (n) send_rand_bits(OP_TICK);
  endtask

  task automatic drain_results();
    while (tracker.due_words.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [21:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    tracker.set_reg(idx, val);
  endtask

  // registers only change with the block idle
  task automatic apply_settings(logic [7:0] fs, logic [7:0] fi, logic [15:0] ht,
                                logic [21:0] of);
    in_valid <= 1'b0;
    drain_results();
    write_reg(CFG_FAST_STEP, 22'(fs));
    write_reg(CFG_FADE_INTERVAL, 22'(fi));
    write_reg(CFG_HUE_TIMEOUT, 22'(ht));
    write_reg(CFG_OFF_FORGET, of);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mostly lamp-on traffic with fades, some power cycling and noise
  task automatic random_event();
    int r;
    r = $urandom_range(99);
    if (r < 45)      send_rand_bits(OP_TICK);
    else if (r < 60) send_rand_bits(OP_TURN);
    else if (r < 66) send_rand_bits(OP_CLICK);
    else if (r < 70) send_rand_bits(OP_HOLD);
    else if (r < 74) send_rand_bits(OP_PTURN);
    else if (r < 78) send_rand_bits(OP_TRIPLE);
    else if (r < 85) send_rand_bits(OP_PRESS);
    else if (r < 89) send_rand_bits(OP_RELEASE);
    else             tick_run($urandom_range(2, 40));
  endtask

  initial begin
    int stop_at;
    tracker = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: short timers so every path shows up quickly
    apply_settings(8'd255, 8'd0, 16'd3, 22'd4);
    send_word(OP_CLICK, 1'b0, 1'b0);     // ignored while off
    send_word(OP_TURN, 1'b1, 1'b1);
    send_word(OP_TRIPLE, 1'b0, 1'b0);
    send_word(OP_PRESS, 1'b1, 1'b1);
    send_word(OP_TURN, 1'b1, 1'b1);      // clamps at full
    tick_run(256);                       // fade up to full brightness
    send_word(OP_HOLD, 1'b0, 1'b0);      // already full: levels redone at once
    send_word(OP_PTURN, 1'b1, 1'b0);
    send_word(OP_PTURN, 1'b0, 1'b1);
    send_word(OP_CLICK, 1'b1, 1'b1);     // into hue mode
    send_word(OP_TURN, 1'b1, 1'b0);
    tick_run(2);
    tick_run(6);                         // hue mode times out
    send_word(OP_TRIPLE, 1'b1, 1'b0);
    send_word(OP_TURN, 1'b0, 1'b1);      // clamps at zero
    send_word(OP_RELEASE, 1'b0, 1'b0);
    send_word(OP_RELEASE, 1'b1, 1'b1);   // repeated release
    tick_run(8);                         // off buffer forgotten
    send_word(OP_PRESS, 1'b0, 1'b0);
    send_word(OP_PRESS, 1'b1, 1'b0);     // repeated press

    // random phases over settings and idling patterns
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: apply_settings(FAST_STEP_RST, FADE_INTERVAL_RST, HUE_TIMEOUT_RST, OFF_FORGET_RST);
        1: apply_settings(8'd0, 8'd0, 16'd0, 22'd0);
        2: apply_settings(8'd255, 8'd255, 16'hFFFF, 22'h3FFFFF);
        default: apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 6)),
                                16'($urandom_range(0, 60)), 22'($urandom_range(0, 80)));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      stop_at = words_sent + PHASE_WORDS;
      while (words_sent < stop_at) random_event();
    end
    in_valid <= 1'b0;

    drain_results();
    repeat (20) @(posedge clk);
    if (tracker.fail_count == 0)
      $display("[warm_cold_led_dimmer_controller_unit] OK");
    else
      $display("[warm_cold_led_dimmer_controller_unit] ERROR");
    $finish;
  end
endmodule

### warm_cold_led_dimmer_controller_unit.f
+incdir+sv
sv/wcld_pkg.sv
sv/warm_cold_led_dimmer_controller_unit.sv
sv/wcld_checker.sv
tb/tb.sv
